// ===== rtl/icl_pkg.sv =====
// shared types and constants for the interpolated cosine lookup
// depends on nothing; imported by every module of the block
package icl_pkg;

    localparam int ANGLE_W = 22;
    localparam int COS_W   = 16;
    localparam int TAB_W   = 32;
    localparam int WGT_W   = 16;
    localparam int R_W     = 31;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint signed   ONE_Q30 = 64'sd1073741824;
    localparam longint unsigned SCALE_R = ((64'd1 << 62) + PI_Q30 / 2) / PI_Q30;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic        [ANGLE_W-1:0] mag_t;
    typedef logic signed [COS_W-1:0]   cosine_t;
    typedef logic signed [TAB_W-1:0]   tab_t;
    typedef logic        [WGT_W-1:0]   wgt_t;

    localparam cosine_t COS_MAX = 16'sd16384;

endpackage

// ===== rtl/icl_position.sv =====
// table position stages: magnitude, scaling multiplies, modulo reduction
// depends on icl_pkg
module icl_position
    import icl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 360,
    parameter int FRACTION_BITS = 16,
    localparam int KW = $clog2(TABLE_ENTRIES)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  angle_t        angle,
    output logic          pos_valid,
    output logic [KW-1:0] pos_k,
    output logic [KW-1:0] pos_k1,
    output wgt_t          pos_frac
);

    localparam int SH      = FRACTION_BITS + 33;
    localparam int FULL_W  = (66 > SH + KW) ? 66 : SH + KW;
    localparam int MR_W    = (53 > SH + KW) ? 53 : SH + KW;
    localparam longint unsigned SCALE_C = longint'(TABLE_ENTRIES) * SCALE_R;
    localparam logic [ANGLE_W-1:0] C_LO = SCALE_C[ANGLE_W-1:0];
    localparam logic [20:0]        C_HI = SCALE_C[42:ANGLE_W];
    localparam logic [R_W-1:0]     R_K  = SCALE_R[R_W-1:0];
    localparam logic [KW-1:0]      N_K  = KW'(TABLE_ENTRIES);
    localparam logic [KW-1:0]      K_LAST = KW'(TABLE_ENTRIES - 1);

    // stage 1: magnitude
    logic    v1_reg;
    mag_t    mag_reg;
    mag_t    mag_next;

    // stage 2: partial products and turn count
    logic          v2_reg;
    logic [43:0]   p_lo_reg;
    logic [43:0]   p_lo_next;
    logic [42:0]   p_hi_reg;
    logic [42:0]   p_hi_next;
    logic [MR_W-1:0] mr;
    logic [KW-1:0] q_reg;
    logic [KW-1:0] q_next;

    // stage 3: full position and whole-turn offset
    logic            v3_reg;
    logic [FULL_W-1:0] full;
    wgt_t            t3_reg;
    wgt_t            t3_next;
    logic [KW-1:0]   ip_reg;
    logic [KW-1:0]   ip_next;
    logic [KW-1:0]   qn_reg;
    logic [KW-1:0]   qn_next;

    // stage 4: entry pair
    logic          v4_reg;
    wgt_t          t4_reg;
    logic [KW-1:0] k_reg;
    logic [KW-1:0] k_next;
    logic [KW-1:0] k1_reg;
    logic [KW-1:0] k1_next;

    assign mag_next  = angle[ANGLE_W-1] ? (~angle + 1'b1) : angle;

    assign p_lo_next = mag_reg * C_LO;
    assign p_hi_next = mag_reg * C_HI;
    assign mr        = mag_reg * R_K;
    assign q_next    = mr[SH +: KW];

    assign full      = (FULL_W'(p_hi_reg) << ANGLE_W) + FULL_W'(p_lo_reg);
    assign t3_next   = full[FRACTION_BITS + 17 +: WGT_W];
    assign ip_next   = full[SH +: KW];
    assign qn_next   = KW'(q_reg * N_K);

    assign k_next    = ip_reg - qn_reg;
    assign k1_next   = (k_next == K_LAST) ? '0 : k_next + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg  <= mag_next;
            p_lo_reg <= p_lo_next;
            p_hi_reg <= p_hi_next;
            q_reg    <= q_next;
            t3_reg   <= t3_next;
            ip_reg   <= ip_next;
            qn_reg   <= qn_next;
            t4_reg   <= t3_reg;
            k_reg    <= k_next;
            k1_reg   <= k1_next;
        end
    end

    assign pos_valid = v4_reg;
    assign pos_k     = k_reg;
    assign pos_k1    = k1_reg;
    assign pos_frac  = t4_reg;

endmodule

// ===== rtl/icl_interp.sv =====
// cosine table read, interpolation products, rounding and clamping
// depends on icl_pkg
module icl_interp
    import icl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 360,
    localparam int KW = $clog2(TABLE_ENTRIES)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          pos_valid,
    input  logic [KW-1:0] pos_k,
    input  logic [KW-1:0] pos_k1,
    input  wgt_t          pos_frac,
    output logic          tail_valid,
    output cosine_t       tail_cos
);

    localparam logic signed [50:0] RND = 51'sd1 <<< 31;

    // cos(2*pi*i/N) in Q2.30 from a folded Taylor series
    function automatic tab_t cos_entry(input int unsigned i);
        longint unsigned a;
        longint unsigned m;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint signed   acc;
        logic            neg;
        a   = (i <= TABLE_ENTRIES - i) ? longint'(i) : longint'(TABLE_ENTRIES - i);
        m   = 2 * a;
        neg = 1'b0;
        if (2 * m > TABLE_ENTRIES)
        begin
            m   = TABLE_ENTRIES - m;
            neg = 1'b1;
        end
        x    = (PI_Q30 * m + TABLE_ENTRIES / 2) / TABLE_ENTRIES;
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        acc  = ONE_Q30;
        term = ((term * x2) >> 30) / 64'd2;   acc = acc - longint'(term);
        term = ((term * x2) >> 30) / 64'd12;  acc = acc + longint'(term);
        term = ((term * x2) >> 30) / 64'd30;  acc = acc - longint'(term);
        term = ((term * x2) >> 30) / 64'd56;  acc = acc + longint'(term);
        term = ((term * x2) >> 30) / 64'd90;  acc = acc - longint'(term);
        term = ((term * x2) >> 30) / 64'd132; acc = acc + longint'(term);
        term = ((term * x2) >> 30) / 64'd182; acc = acc - longint'(term);
        term = ((term * x2) >> 30) / 64'd240; acc = acc + longint'(term);
        term = ((term * x2) >> 30) / 64'd306; acc = acc - longint'(term);
        term = ((term * x2) >> 30) / 64'd380; acc = acc + longint'(term);
        if (acc > ONE_Q30)
        begin
            acc = ONE_Q30;
        end
        if (acc < -ONE_Q30)
        begin
            acc = -ONE_Q30;
        end
        if (neg)
        begin
            acc = -acc;
        end
        return tab_t'(acc);
    endfunction

    tab_t rom_tab [TABLE_ENTRIES];

    for (genvar gi = 0; gi < TABLE_ENTRIES; gi++)
    begin : g_rom
        assign rom_tab[gi] = cos_entry(gi);
    end

    // stage 5: table read
    logic v5_reg;
    tab_t ta_reg;
    tab_t tb_reg;
    wgt_t t5_reg;

    // stage 6: weighted products
    logic              v6_reg;
    logic [WGT_W:0]    w0;
    logic signed [49:0] pa_reg;
    logic signed [49:0] pa_next;
    logic signed [49:0] pb_reg;
    logic signed [49:0] pb_next;

    // stage 7: round and clamp
    logic               v7_reg;
    logic signed [50:0] sum;
    logic signed [18:0] rnd;
    cosine_t            res_reg;
    cosine_t            res_next;

    assign w0      = {1'b1, {WGT_W{1'b0}}} - {1'b0, t5_reg};
    assign pa_next = ta_reg * $signed({1'b0, w0});
    assign pb_next = tb_reg * $signed({2'b00, t5_reg});

    assign sum = pa_reg + pb_reg + RND;
    assign rnd = $signed(sum[50:32]);

    always_comb
    begin
        if (rnd > 19'sd16384)
        begin
            res_next = COS_MAX;
        end
        else if (rnd < -19'sd16384)
        begin
            res_next = -COS_MAX;
        end
        else
        begin
            res_next = rnd[COS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= pos_valid;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ta_reg  <= rom_tab[pos_k];
            tb_reg  <= rom_tab[pos_k1];
            t5_reg  <= pos_frac;
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
            res_reg <= res_next;
        end
    end

    assign tail_valid = v7_reg;
    assign tail_cos   = res_reg;

endmodule

// ===== rtl/interpolated_cosine_lookup.sv =====
// interpolated cosine lookup: Q5.16 angle in, Q1.14 cosine out; uses icl_pkg,
// icl_position and icl_interp. an accepted angle passes through stages 1 to 7, then the output register
// throughput one angle per cycle while the skid register is empty: seven register stages plus an output register
// and a one-entry skid register; a stall freezes all stages together
// reset is asynchronous active low and clears valid bits only; the cosine table is constant
module interpolated_cosine_lookup
    import icl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 360,
    parameter int FRACTION_BITS = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    angle_valid,
    output logic    angle_ready,
    input  angle_t  angle,
    output logic    cosine_valid,
    input  logic    cosine_ready,
    output cosine_t cosine
);

    localparam int KW = $clog2(TABLE_ENTRIES);

    logic          en;
    logic          pos_valid;
    logic [KW-1:0] pos_k;
    logic [KW-1:0] pos_k1;
    wgt_t          pos_frac;
    logic          tail_valid;
    cosine_t       tail_cos;

    logic    out_valid_reg;
    cosine_t out_data_reg;
    logic    skid_valid_reg;
    cosine_t skid_data_reg;

    assign en          = !skid_valid_reg;
    assign angle_ready = en;

    icl_position #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_position (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (angle_valid),
        .angle     (angle),
        .pos_valid (pos_valid),
        .pos_k     (pos_k),
        .pos_k1    (pos_k1),
        .pos_frac  (pos_frac)
    );

    icl_interp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_interp (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .pos_valid  (pos_valid),
        .pos_k      (pos_k),
        .pos_k1     (pos_k1),
        .pos_frac   (pos_frac),
        .tail_valid (tail_valid),
        .tail_cos   (tail_cos)
    );

    // output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                if (cosine_ready)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (tail_valid)
            begin
                if (out_valid_reg && !cosine_ready)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (cosine_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (cosine_ready)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (tail_valid)
        begin
            if (out_valid_reg && !cosine_ready)
            begin
                skid_data_reg <= tail_cos;
            end
            else
            begin
                out_data_reg <= tail_cos;
            end
        end
    end

    assign cosine_valid = out_valid_reg;
    assign cosine       = out_data_reg;

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        cosine_valid |-> (cosine <= COS_MAX && cosine >= -COS_MAX))
        else $error("cosine out of range");

    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_valid && en && out_valid_reg && !cosine_ready) |=> skid_valid_reg)
        else $error("stalled result not captured in skid entry");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && cosine_ready) |=> (!skid_valid_reg && out_valid_reg))
        else $error("skid entry not moved to output register");
`endif

endmodule

// ===== sim/interpolated_cosine_lookup_test.sv =====
// testbench for interpolated_cosine_lookup: drives angle requests with random gaps and stalls,
// predicts each cosine from its own table and interpolation, checks results in order
// depends on icl_pkg and the interpolated_cosine_lookup rtl
module interpolated_cosine_lookup_test;

    import icl_pkg::ANGLE_W;
    import icl_pkg::angle_t;
    import icl_pkg::cosine_t;

    localparam int TABLE_N    = 360;
    localparam int FRAC_BITS  = 16;
    localparam int TWO_PI_Q16 = 411775;
    localparam int RANDOM_N   = 1625;
    localparam int CHUNK_N    = 325;
    localparam int LATENCY    = 8;
    localparam int unsigned CYCLE_LIMIT = 600000;

    localparam longint unsigned PI_Q30_TB  = 64'd3373259426;
    localparam longint          ONE_Q30_TB = 64'sd1073741824;
    localparam longint          COS_LIMIT  = 16384;

    class cosine_scoreboard;
        longint          rom_q30 [TABLE_N];
        longint unsigned scale_r;
        cosine_t         expected_cosines [$];
        int unsigned     fail_count;

        function new();
            for (int i = 0; i < TABLE_N; i++)
            begin
                rom_q30[i] = table_entry(i);
            end
            scale_r = ((64'd1 << 62) + PI_Q30_TB / 2) / PI_Q30_TB;
            fail_count = 0;
        endfunction

        // taylor series of cos over the first quadrant, folded by symmetry
        function longint table_entry(input int unsigned i);
            longint unsigned n;
            longint unsigned a;
            longint unsigned m;
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint          acc;
            bit              neg;
            n = TABLE_N;
            a = (i <= n - i) ? i : n - i;
            m = 2 * a;
            neg = 0;
            acc = ONE_Q30_TB;
            if (2 * m > n)
            begin
                m = n - m;
                neg = 1;
            end
            x = (PI_Q30_TB * m + n / 2) / n;
            x2 = (x * x) >> 30;
            term = ONE_Q30_TB;
            for (int k = 1; k <= 10; k++)
            begin
                term = ((term * x2) >> 30) / ((2 * k - 1) * (2 * k));
                if (k % 2 == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc > ONE_Q30_TB)
                acc = ONE_Q30_TB;
            if (acc < -ONE_Q30_TB)
                acc = -ONE_Q30_TB;
            return neg ? -acc : acc;
        endfunction

        function cosine_t predict_cosine(input angle_t a);
            logic [ANGLE_W-1:0] bits;
            longint unsigned    raw;
            longint unsigned    mag;
            longint unsigned    prod;
            longint unsigned    pos;
            longint             t;
            int unsigned        k;
            int unsigned        k1;
            longint             v;
            longint             res;
            bits = a;
            raw = bits;
            mag = bits[ANGLE_W-1] ? (64'd1 << ANGLE_W) - raw : raw;
            prod = mag * TABLE_N;
            pos = (((prod >> 16) * scale_r) + (((prod & 64'hFFFF) * scale_r) >> 16))
                  >> (FRAC_BITS + 1);
            t = longint'(pos & 64'hFFFF);
            k = int'((pos >> 16) % TABLE_N);
            k1 = (k + 1 == TABLE_N) ? 0 : k + 1;
            v = rom_q30[k] * (65536 - t) + rom_q30[k1] * t;
            res = ((v + (64'sd1 << 47) + (64'sd1 << 31)) >>> 32) - 32768;
            if (res > COS_LIMIT)
                res = COS_LIMIT;
            if (res < -COS_LIMIT)
                res = -COS_LIMIT;
            return cosine_t'(res);
        endfunction

        function void note_angle(input angle_t a);
            expected_cosines.push_back(predict_cosine(a));
        endfunction

        function void check_cosine(input cosine_t got);
            cosine_t want;
            if (expected_cosines.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected cosine %0d with no request pending", got);
            end
            else
            begin
                want = expected_cosines.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("cosine mismatch: expected %0d, actual %0d", want, got);
                end
            end
        endfunction

        function int pending();
            return expected_cosines.size();
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    angle_valid;
    logic    angle_ready;
    angle_t  angle;
    logic    cosine_valid;
    logic    cosine_ready;
    cosine_t cosine;

    cosine_scoreboard sb;
    bit               quiet;
    int unsigned      cycle_count = 0;

    interpolated_cosine_lookup #(
        .TABLE_ENTRIES(TABLE_N),
        .FRACTION_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .angle_valid(angle_valid),
        .angle_ready(angle_ready),
        .angle(angle),
        .cosine_valid(cosine_valid),
        .cosine_ready(cosine_ready),
        .cosine(cosine)
    );

    initial
    begin
        clk = 0;
    end

    always #6 clk = ~clk;

    initial
    begin
        sb = new();
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && angle_valid && angle_ready)
            sb.note_angle(angle);
        if (rst_n && cosine_valid && cosine_ready)
            sb.check_cosine(cosine);
    end

    function automatic int pick_gap(input int floor_len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return floor_len;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side backpressure
    initial
    begin
        int hold;
        hold = 0;
        cosine_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                cosine_ready = 0;
                hold--;
            end
            else
            begin
                cosine_ready = 1;
                if (!quiet && $urandom_range(0, 2) == 0)
                    hold = pick_gap(1);
            end
        end
    end

    task automatic send_angle(input angle_t a);
        int gap;
        angle = a;
        angle_valid = 1;
        @(posedge clk);
        while (!angle_ready)
            @(posedge clk);
        @(negedge clk);
        gap = quiet ? 0 : pick_gap(0);
        if (gap > 0)
        begin
            angle_valid = 0;
            angle = angle_t'($urandom);
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        angle_valid = 0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    function automatic angle_t random_angle();
        int sel;
        int v;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            return angle_t'($urandom);
        if (sel < 75)
        begin
            v = int'($urandom_range(0, 2 * TWO_PI_Q16)) - TWO_PI_Q16;
            return angle_t'(v);
        end
        if (sel < 92)
        begin
            // near a table entry boundary, possibly several turns out
            v = (int'($urandom_range(0, TABLE_N - 1)) * TWO_PI_Q16) / TABLE_N;
            v = v + int'($urandom_range(0, 6)) - 3 + TWO_PI_Q16 * int'($urandom_range(0, 4));
            if ($urandom_range(0, 1) == 1)
                v = -v;
            return angle_t'(v);
        end
        case ($urandom_range(0, 4))
            0: return 22'sh1FFFFF;
            1: return 22'sh200000;
            2: return 22'sh200001;
            3: return 22'sh1FFFFE;
            default: return '0;
        endcase
    endfunction

    angle_t corner_angles [24] = '{
        22'sd0, 22'sd1, -22'sd1, 22'sh1FFFFF, 22'sh200000, 22'sh155555, 22'sh2AAAAA,
        22'sd102944, -22'sd102944, 22'sd205887, -22'sd205887, 22'sd308831,
        22'sd411774, 22'sd411775, 22'sd411777, 22'sd410632, 22'sd411203,
        22'sd823550, 22'sd1966080, -22'sd1966080, 22'sd572, 22'sd1144,
        22'sd32768, -22'sd65536
    };

    initial
    begin
        rst_n = 0;
        angle_valid = 0;
        angle = '0;
        quiet = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        foreach (corner_angles[i])
            send_angle(corner_angles[i]);
        wait_drained();

        for (int chunk = 0; chunk < RANDOM_N / CHUNK_N; chunk++)
        begin
            quiet = (chunk == 1);
            for (int i = 0; i < CHUNK_N; i++)
                send_angle(random_angle());
            if (chunk == 2)
                wait_drained();
        end
        quiet = 0;
        angle_valid = 0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY * 3) @(posedge clk);

        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/icl_pkg.sv
rtl/icl_position.sv
rtl/icl_interp.sv
rtl/interpolated_cosine_lookup.sv
sim/interpolated_cosine_lookup_test.sv
